FILE: rtl/played_frame_backtrace_assert.svh
// ----------------------------------------------------------------------------
// Played frame backtrace assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PLAYED_FRAME_BACKTRACE_ASSERT_SVH
`define PLAYED_FRAME_BACKTRACE_ASSERT_SVH

// same-cycle implication
`define PFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("played_frame_backtrace: check failed");

// next-cycle implication
`define PFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("played_frame_backtrace: check failed");

`endif

FILE: rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared widths, command codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 37;

  localparam int CMD_W      = 2;
  localparam int NUMBER_W   = 24;
  localparam int BYTES_W    = 20;
  localparam int RESUME_W   = 25;
  localparam int CFG_W      = 24;
  localparam int CFG_INDEX_W = 4;
  localparam int BUDGET_W   = 26;
  localparam int ENTRY_W    = NUMBER_W + BYTES_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_BUDGET = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_EXTRA = 4'd1;

  localparam logic [CFG_W-1:0] FORWARD_BUDGET_RESET = 24'd262144;
  localparam logic [CFG_W-1:0] BACKWARD_EXTRA_RESET = 24'd262144;

  typedef struct packed {
    logic do_clear;
    logic do_add;
    logic start_get;
    logic walk_en;
    logic load_out;
  } pfb_cmd_t;

  typedef struct packed {
    logic walk_done;
  } pfb_status_t;

endpackage

FILE: rtl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// pfb_ctrl
// Command decode and walk sequencing; owns the output word valid flag.
// ----------------------------------------------------------------------------
module pfb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pfb_pkg::CMD_W-1:0]  cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pfb_pkg::pfb_cmd_t          ctl,
  input  pfb_pkg::pfb_status_t       sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            pfb_pkg::CMD_CLEAR: ctl.do_clear = 1'b1;
            pfb_pkg::CMD_ADD:   ctl.do_add   = 1'b1;
            pfb_pkg::CMD_GET: begin
              ctl.start_get = 1'b1;
              state_next    = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        ctl.walk_en = 1'b1;
        if (sts.walk_done) begin
          if (slot_free) begin
            ctl.load_out = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/pfb_dp.sv
// ----------------------------------------------------------------------------
// pfb_dp
// History store, pointers, configuration registers and the budget walk.
// ----------------------------------------------------------------------------
module pfb_dp #(
  parameter int HISTORY_DEPTH = pfb_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfb_pkg::CFG_W-1:0]          cfg_data,
  input  logic [pfb_pkg::NUMBER_W-1:0]       frame_number,
  input  logic [pfb_pkg::BYTES_W-1:0]        frame_bytes,
  input  logic                               direction_forward,
  output logic signed [pfb_pkg::RESUME_W-1:0] resume_frame,
  output logic                               history_nonempty,
  input  pfb_pkg::pfb_cmd_t                  ctl,
  output pfb_pkg::pfb_status_t               sts
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int BW = pfb_pkg::BUDGET_W;

  logic [pfb_pkg::CFG_W-1:0]    forward_budget;
  logic [pfb_pkg::CFG_W-1:0]    backward_extra;
  logic [PW-1:0]                write_pointer;
  logic [CW-1:0]                entry_count;
  logic [PW-1:0]                issue_ptr;
  logic [CW-1:0]                issue_left;
  logic                         pend;
  logic [BW-1:0]                budget;
  logic [pfb_pkg::RESUME_W-1:0] result;
  logic                         visited;

  logic [PW-1:0]                rd_addr;
  logic [pfb_pkg::ENTRY_W-1:0]  rd_data;
  logic [pfb_pkg::NUMBER_W-1:0] rd_number;
  logic [pfb_pkg::BYTES_W-1:0]  rd_bytes;
  logic [BW-1:0]                budget_start;
  logic [BW-1:0]                budget_next;
  logic [pfb_pkg::RESUME_W-1:0] result_next;
  logic                         visited_next;
  logic                         more;
  logic                         issue;

  pfb_ram #(
    .WIDTH(pfb_pkg::ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ctl.do_add),
    .wr_addr(write_pointer),
    .wr_data({frame_number, frame_bytes}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_number = rd_data[pfb_pkg::ENTRY_W-1:pfb_pkg::BYTES_W];
  assign rd_bytes  = rd_data[pfb_pkg::BYTES_W-1:0];

  assign rd_addr = (issue_ptr == '0) ? PW'(HISTORY_DEPTH - 1) : issue_ptr - 1'b1;

  assign budget_start = {{(BW - pfb_pkg::CFG_W){1'b0}}, forward_budget}
                      + (direction_forward ? '0
                         : {{(BW - pfb_pkg::CFG_W){1'b0}}, backward_extra});

  always_comb begin
    budget_next  = budget;
    result_next  = result;
    visited_next = visited;
    if (ctl.walk_en && pend) begin
      budget_next  = budget - {{(BW - pfb_pkg::BYTES_W){1'b0}}, rd_bytes};
      result_next  = {1'b0, rd_number} - 1'b1;
      visited_next = 1'b1;
    end
  end

  assign more          = !budget_next[BW-1] && (budget_next != '0);
  assign issue         = (issue_left != '0) && more;
  assign sts.walk_done = !issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_budget <= pfb_pkg::FORWARD_BUDGET_RESET;
      backward_extra <= pfb_pkg::BACKWARD_EXTRA_RESET;
      write_pointer  <= '0;
      entry_count    <= '0;
      pend           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfb_pkg::REG_FORWARD_BUDGET: forward_budget <= cfg_data;
          pfb_pkg::REG_BACKWARD_EXTRA: backward_extra <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.do_clear) begin
        write_pointer <= '0;
        entry_count   <= '0;
      end
      if (ctl.do_add) begin
        write_pointer <= (write_pointer == PW'(HISTORY_DEPTH - 1)) ? '0
                         : write_pointer + 1'b1;
        if (entry_count != CW'(HISTORY_DEPTH)) begin
          entry_count <= entry_count + 1'b1;
        end
      end
      if (ctl.start_get) begin
        pend <= 1'b0;
      end else if (ctl.walk_en) begin
        pend <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_get) begin
      budget     <= budget_start;
      issue_ptr  <= write_pointer;
      issue_left <= entry_count;
      result     <= '1;
      visited    <= 1'b0;
    end else if (ctl.walk_en) begin
      budget  <= budget_next;
      result  <= result_next;
      visited <= visited_next;
      if (issue) begin
        issue_ptr  <= rd_addr;
        issue_left <= issue_left - 1'b1;
      end
    end
    if (ctl.load_out) begin
      resume_frame     <= result_next;
      history_nonempty <= visited_next;
    end
  end

endmodule

FILE: rtl/played_frame_backtrace.sv
// ----------------------------------------------------------------------------
// played_frame_backtrace
// Circular history of played frames with a byte-budget backtrace lookup.
//
//   channel  dir  handshake              word
//   in       in   in_valid / in_ready    cmd, frame_number, frame_bytes,
//                                        direction_forward
//   out      out  out_valid / out_ready  resume_frame, history_nonempty
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Clear and add leave the block idle; the next word is taken the cycle after.
// Get walks the history at one entry per cycle through the store's single
// read port, visiting at most HISTORY_DEPTH entries.
// The result sits in an output register; while it waits, clear and add words
// are still taken, and a following get holds its result until the slot frees.
// Reset is synchronous and empties the history; the store itself is not swept.
// ----------------------------------------------------------------------------
`include "played_frame_backtrace_assert.svh"

module played_frame_backtrace #(
  parameter int HISTORY_DEPTH = pfb_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pfb_pkg::CMD_W-1:0]           cmd,
  input  logic [pfb_pkg::NUMBER_W-1:0]        frame_number,
  input  logic [pfb_pkg::BYTES_W-1:0]         frame_bytes,
  input  logic                                direction_forward,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfb_pkg::RESUME_W-1:0] resume_frame,
  output logic                                history_nonempty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfb_pkg::CFG_W-1:0]           cfg_data
);

  pfb_pkg::pfb_cmd_t    ctl;
  pfb_pkg::pfb_status_t sts;

  assign cfg_ready = 1'b1;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  pfb_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .frame_number     (frame_number),
    .frame_bytes      (frame_bytes),
    .direction_forward(direction_forward),
    .resume_frame     (resume_frame),
    .history_nonempty (history_nonempty),
    .ctl              (ctl),
    .sts              (sts)
  );

  `PFB_ASSERT_NOW(a_no_walk_when_ready, in_ready, !ctl.walk_en)
  `PFB_ASSERT_NOW(a_load_into_free_slot, ctl.load_out, !out_valid || out_ready)
  `PFB_ASSERT_NEXT(a_load_sets_valid, ctl.load_out, out_valid)
  `PFB_ASSERT_NEXT(a_get_goes_busy, in_valid && in_ready && cmd == pfb_pkg::CMD_GET, !in_ready)

endmodule

FILE: tb/played_frame_backtrace_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// played_frame_backtrace_test
// Self-checking bench for the played-frame backtrace history. A tracker keeps
// its own copy of the history and both budget registers. It predicts each
// lookup and checks every result word in order. The bench starts with
// directed words, then runs bursty random traffic under seven register
// settings. The receiver stalls, and at one point holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [pfb_pkg::RESUME_W-1:0] resume_frame;
  logic                                history_nonempty;
} backtrace_t;

class resume_frame_tracker;
  logic [pfb_pkg::NUMBER_W-1:0] numbers [pfb_pkg::HISTORY_DEPTH_DEFAULT];
  logic [pfb_pkg::BYTES_W-1:0]  lengths [pfb_pkg::HISTORY_DEPTH_DEFAULT];
  int                           head;
  int                           filled;
  logic [pfb_pkg::CFG_W-1:0]    forward_budget;
  logic [pfb_pkg::CFG_W-1:0]    backward_extra;
  backtrace_t                   pending_resumes[$];
  int                           errors;
  int                           adds, clears, ignored, lookups, full_lookups, long_walks;

  function new();
    head           = 0;
    filled         = 0;
    forward_budget = pfb_pkg::FORWARD_BUDGET_RESET;
    backward_extra = pfb_pkg::BACKWARD_EXTRA_RESET;
    errors         = 0;
    adds           = 0;
    clears         = 0;
    ignored        = 0;
    lookups        = 0;
    full_lookups   = 0;
    long_walks     = 0;
  endfunction

  function void write_register(logic [pfb_pkg::CFG_INDEX_W-1:0] index,
                               logic [pfb_pkg::CFG_W-1:0] data);
    if (index == pfb_pkg::REG_FORWARD_BUDGET) begin
      forward_budget = data;
    end else if (index == pfb_pkg::REG_BACKWARD_EXTRA) begin
      backward_extra = data;
    end
  endfunction

  function void note_word(logic [pfb_pkg::CMD_W-1:0] cmd,
                          logic [pfb_pkg::NUMBER_W-1:0] number,
                          logic [pfb_pkg::BYTES_W-1:0] nbytes,
                          logic forward);
    longint     budget;
    int         p;
    int         left;
    int         visited;
    backtrace_t want;
    if (cmd == pfb_pkg::CMD_CLEAR) begin
      head   = 0;
      filled = 0;
      clears++;
    end else if (cmd == pfb_pkg::CMD_ADD) begin
      numbers[head] = number;
      lengths[head] = nbytes;
      head = (head == pfb_pkg::HISTORY_DEPTH_DEFAULT - 1) ? 0 : head + 1;
      if (filled < pfb_pkg::HISTORY_DEPTH_DEFAULT) filled++;
      adds++;
    end else if (cmd == pfb_pkg::CMD_GET) begin
      budget = longint'(forward_budget);
      if (!forward) budget += longint'(backward_extra);
      want.resume_frame     = '1;
      want.history_nonempty = 1'b0;
      p       = head;
      left    = filled;
      visited = 0;
      // walk newest to oldest while budget remains
      while (left != 0 && budget > 0) begin
        p = (p == 0) ? pfb_pkg::HISTORY_DEPTH_DEFAULT - 1 : p - 1;
        want.resume_frame     = {1'b0, numbers[p]} - 25'd1;
        want.history_nonempty = 1'b1;
        budget -= longint'(lengths[p]);
        left--;
        visited++;
      end
      pending_resumes.push_back(want);
      lookups++;
      if (filled == pfb_pkg::HISTORY_DEPTH_DEFAULT) full_lookups++;
      if (visited >= 20) long_walks++;
    end else begin
      ignored++;
    end
  endfunction

  function void check_result(logic signed [pfb_pkg::RESUME_W-1:0] got_frame,
                             logic got_nonempty);
    backtrace_t want;
    if (pending_resumes.size() == 0) begin
      if (errors < 40) $error("result word with nothing expected: resume_frame %0d", got_frame);
      errors++;
    end else begin
      want = pending_resumes.pop_front();
      if (got_frame !== want.resume_frame) begin
        if (errors < 40) $error("resume_frame: expected %0d, got %0d",
                                want.resume_frame, got_frame);
        errors++;
      end
      if (got_nonempty !== want.history_nonempty) begin
        if (errors < 40) $error("history_nonempty: expected %0d, got %0d",
                                want.history_nonempty, got_nonempty);
        errors++;
      end
    end
  endfunction

  function int outstanding();
    return pending_resumes.size();
  endfunction
endclass

module played_frame_backtrace_test;

  localparam int DEPTH              = pfb_pkg::HISTORY_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES      = DEPTH + 13;
  localparam int STUCK_LIMIT        = 4000;
  localparam int LONG_HOLD          = 600;
  localparam int NUM_SETTINGS       = 7;
  localparam int RANDOM_PER_SETTING = 220;

  localparam logic [pfb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_RARELY} stall_mode_t;

  typedef logic [pfb_pkg::NUMBER_W-1:0] number_t;
  typedef logic [pfb_pkg::BYTES_W-1:0]  length_t;
  typedef logic [pfb_pkg::CFG_W-1:0]    cfg_word_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [pfb_pkg::CMD_W-1:0]           cmd = pfb_pkg::CMD_CLEAR;
  logic [pfb_pkg::NUMBER_W-1:0]        frame_number = '0;
  logic [pfb_pkg::BYTES_W-1:0]         frame_bytes = '0;
  logic                                direction_forward = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [pfb_pkg::RESUME_W-1:0] resume_frame;
  logic                                history_nonempty;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [pfb_pkg::CFG_INDEX_W-1:0]     cfg_index = pfb_pkg::REG_FORWARD_BUDGET;
  logic [pfb_pkg::CFG_W-1:0]           cfg_data = '0;

  resume_frame_tracker          tracker;
  int                           holds_asked = 0;
  int                           holds_served = 0;
  int                           hold_left = 0;
  stall_mode_t                  stall_mode = READY_ALWAYS;
  int                           mode_left = 0;
  int                           stuck_cycles = 0;
  int                           settings_loaded = 0;
  logic [pfb_pkg::NUMBER_W-1:0] next_frame = 24'd100;

  played_frame_backtrace #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .frame_number      (frame_number),
    .frame_bytes       (frame_bytes),
    .direction_forward (direction_forward),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .resume_frame      (resume_frame),
    .history_nonempty  (history_nonempty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        tracker.note_word(cmd, frame_number, frame_bytes, direction_forward);
      end
      if (out_valid && out_ready) tracker.check_result(resume_frame, history_nonempty);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        READY_HALF:   out_ready <= ($urandom_range(0, 1) != 0);
        default:      out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, tracker.outstanding());
      $display("played_frame_backtrace: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(logic [pfb_pkg::CMD_W-1:0] c, logic [pfb_pkg::NUMBER_W-1:0] number,
                           logic [pfb_pkg::BYTES_W-1:0] nbytes, logic forward);
    in_valid          <= 1'b1;
    cmd               <= c;
    frame_number      <= number;
    frame_bytes       <= nbytes;
    direction_forward <= forward;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_register(logic [pfb_pkg::CFG_INDEX_W-1:0] index,
                                logic [pfb_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(int idx);
    logic [pfb_pkg::CFG_W-1:0] budget;
    logic [pfb_pkg::CFG_W-1:0] extra;
    case (idx)
      0:       begin budget = 24'd262144;  extra = 24'd262144;  end
      1:       begin budget = 24'd1;       extra = 24'd0;       end
      2:       begin budget = 24'hFFFFFF;  extra = 24'hFFFFFF;  end
      3:       begin budget = 24'd0;       extra = 24'hFFFFFF;  end
      4:       begin
        budget = cfg_word_t'($urandom_range(1, 600000));
        extra  = cfg_word_t'($urandom_range(0, 600000));
      end
      5:       begin budget = 24'd20;      extra = 24'd15000;   end
      default: begin
        budget = cfg_word_t'($urandom_range(0, 24'hFFFFFF));
        extra  = cfg_word_t'($urandom_range(0, 24'hFFFFFF));
      end
    endcase
    write_register(pfb_pkg::REG_FORWARD_BUDGET, budget);
    write_register(pfb_pkg::REG_BACKWARD_EXTRA, extra);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [pfb_pkg::BYTES_W-1:0] pick_length();
    case ($urandom_range(0, 19))
      0:             return '0;
      1:             return '1;
      2, 3, 4:       return length_t'($urandom_range(0, 20'hFFFFF));
      5, 6, 7, 8:    return length_t'($urandom_range(0, 200000));
      default:       return length_t'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic logic [pfb_pkg::NUMBER_W-1:0] pick_frame_number();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return number_t'($urandom_range(0, 24'hFFFFFF));
      default: begin
        next_frame = next_frame + 24'd1;
        return next_frame;
      end
    endcase
  endfunction

  task automatic random_words(int count, bit pause_midway);
    int                        sent;
    int                        burst_left;
    int                        gap;
    int                        pick;
    logic [pfb_pkg::CMD_W-1:0] c;
    sent       = 0;
    burst_left = $urandom_range(1, 24);
    while (sent < count) begin
      if (pause_midway && sent == count / 2) begin
        wait_drained();
        pause_midway = 0;
      end
      if (burst_left == 0) begin
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) c = pfb_pkg::CMD_CLEAR;
      else if (pick < 6) c = CMD_UNUSED;
      else if (pick < 62) c = pfb_pkg::CMD_ADD;
      else c = pfb_pkg::CMD_GET;
      send_word(c, pick_frame_number(), pick_length(), 1'($urandom_range(0, 1)));
      if (c != CMD_UNUSED) sent++;
      burst_left--;
    end
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty history, both directions, ignored command
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'hFFFFFF, 20'hFFFFF, 1'b0);
    send_word(CMD_UNUSED, 24'hFFFFFF, 20'hFFFFF, 1'b1);
    // frame zero with zero length
    send_word(pfb_pkg::CMD_ADD, 24'd0, 20'd0, 1'b0);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b1);
    // largest frame and length
    send_word(pfb_pkg::CMD_ADD, 24'hFFFFFF, 20'hFFFFF, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b0);
    // length that uses up the budget exactly
    send_word(pfb_pkg::CMD_ADD, 24'd1, 20'd15000, 1'b0);
    send_word(pfb_pkg::CMD_ADD, 24'd2, 20'd262144, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'hAAAAAA, 20'h55555, 1'b1);
    send_word(pfb_pkg::CMD_ADD, 24'h555555, 20'hAAAAA, 1'b0);
    send_word(pfb_pkg::CMD_ADD, 24'hAAAAAA, 20'h55555, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'h555555, 20'hAAAAA, 1'b0);
    send_word(CMD_UNUSED, 24'd0, 20'd0, 1'b0);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b1);
    // clear, then reuse
    send_word(pfb_pkg::CMD_CLEAR, 24'hFFFFFF, 20'hFFFFF, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b1);
    send_word(pfb_pkg::CMD_ADD, 24'd7, 20'd20, 1'b1);
    send_word(pfb_pkg::CMD_GET, 24'd0, 20'd0, 1'b0);
    wait_drained();

    for (int idx = 0; idx < NUM_SETTINGS; idx++) begin
      apply_setting(idx);
      if (idx == 2) holds_asked <= holds_asked + 1;
      random_words(RANDOM_PER_SETTING, idx == 4);
      wait_drained();
    end

    if (tracker.outstanding() != 0) begin
      $error("resume_frame: %0d expected results never arrived", tracker.outstanding());
      tracker.errors++;
    end
    $display("Covered %0d adds, %0d clears, %0d ignored words and %0d lookups",
             tracker.adds, tracker.clears, tracker.ignored, tracker.lookups);
    $display("%0d lookups on a full history, %0d walked 20+ entries, %0d register settings",
             tracker.full_lookups, tracker.long_walks, settings_loaded);
    if (tracker.errors == 0) begin
      $display("played_frame_backtrace: match");
    end else begin
      $display("played_frame_backtrace: mismatch");
    end
    $finish;
  end
endmodule
